// ===== rtl/nonlinear_thermal_plant_step_unit_defines.svh =====
// assertion macros for the plant step unit
`ifndef NONLINEAR_THERMAL_PLANT_STEP_UNIT_DEFINES_SVH
`define NONLINEAR_THERMAL_PLANT_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NTP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define NTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define NTP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ntps_pkg.sv =====
`default_nettype none
package ntps_pkg;
	localparam int FracBitsDefault = 16;
	localparam logic [31:0] TurnPerRad = 32'd683565276;
	localparam logic [31:0] PolyA = 32'd1686629713;
	localparam logic [31:0] PolyB = 32'd693598564;
	localparam logic [31:0] PolyC = 32'd80710703;
	localparam int AddrW = 5;

	typedef enum logic [AddrW-1:0] {
		REG_A1 = 5'd0, REG_A2 = 5'd4, REG_B1 = 5'd8,
		REG_B2 = 5'd12, REG_MODE = 5'd16, REG_INIT = 5'd20
	} reg_addr_t;

	typedef struct packed {
		logic [31:0] u;
		logic        restart;
	} req_t;

	typedef struct packed {
		logic [31:0] a1;
		logic [31:0] a2;
		logic [31:0] b1;
		logic [31:0] b2;
		logic        mode;
		logic [31:0] init;
	} cfg_t;
endpackage
`default_nettype wire

// ===== rtl/ntps_if.sv =====
`default_nettype none
interface ntps_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] control_in;
	logic        restart;
	modport source (output valid, control_in, restart, input ready);
	modport sink (input valid, control_in, restart, output ready);
endinterface

interface ntps_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] plant_out;
	logic        saturated;
	modport source (output valid, plant_out, saturated, input ready);
	modport sink (input valid, plant_out, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/ntps_front.sv =====
`default_nettype none
// two-entry request queue between the input handshake and the datapath
module ntps_front
	import ntps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ntps_in_if.sink   in_ch,
	output req_t      req,
	output logic      req_valid,
	input  wire logic req_take
);
	req_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign req_valid = (cnt_q != 2'd0);
	assign req = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{u: in_ch.control_in, restart: in_ch.restart};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (req_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, req_take};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ntps_back.sv =====
`default_nettype none
// sequenced datapath: one 32x32 multiply per step on a signed or an unsigned multiplier, 64-bit products
module ntps_back
	import ntps_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  req_t      req,
	input  wire logic req_valid,
	output logic      req_take,
	ntps_out_if.source out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_PH, S_X2, S_T, S_T2, S_M, S_B2S, S_A1Y, S_B1U, S_YY,
		S_DLO, S_DHI, S_SUM, S_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] u_q, y_q;
	logic        sneg_q;
	logic [63:0] acc_q;
	logic        dcap_q;
	logic [63:0] q_q;
	logic [31:0] x_q, x2_q, t_q, s_q;
	logic [63:0] dmag_q;
	logic [31:0] out_q;
	logic        sat_q;

	logic signed [63:0] smul;
	logic [63:0]        umul;
	logic signed [31:0] ma, mb;
	logic [31:0]        ua, ub;
	logic [31:0]        am;
	logic [63:0]        fl;
	logic [31:0]        phase;
	logic [29:0]        xl;
	logic [31:0]        xm;
	logic [63:0]        dsum;
	logic signed [63:0] dterm;
	logic signed [64:0] fin;

	assign am = cfg.a2[31] ? (~cfg.a2 + 32'd1) : cfg.a2;
	assign smul = 64'(ma) * 64'(mb);
	assign umul = {32'd0, ua} * {32'd0, ub};
	assign fl = 64'($signed(smul) >>> FRAC_BITS);
	assign phase = smul[FRAC_BITS +: 32];
	assign xl = phase[29:0];
	assign xm = phase[30] ? (32'h4000_0000 - {2'b0, xl}) : {2'b0, xl};
	assign dsum = dmag_q + ((umul << (31 - FRAC_BITS)));
	assign dterm = cfg.a2[31] ? -$signed(dmag_q) : $signed(dmag_q);
	assign fin = {acc_q[63], acc_q} - {dterm[63], dterm};

	always_comb begin
		ma = '0; mb = '0; ua = '0; ub = '0;
		unique case (state_q)
			S_PH:  begin ma = $signed(u_q); mb = $signed(TurnPerRad); end
			S_X2:  begin ua = x_q; ub = x_q; end
			S_T:   begin ua = x2_q; ub = PolyC; end
			S_T2:  begin ua = x2_q; ub = t_q; end
			S_M:   begin ua = x_q; ub = t_q; end
			S_B2S: begin ma = $signed(cfg.b2); mb = $signed(s_q); end
			S_A1Y: begin ma = $signed(cfg.a1); mb = $signed(y_q); end
			S_B1U: begin ma = $signed(cfg.b1); mb = $signed(u_q); end
			S_YY:  begin ma = $signed(y_q); mb = $signed(y_q); end
			S_DLO: begin ua = am; ub = {1'b0, q_q[30:0]}; end
			S_DHI: begin ua = am; ub = q_q[62:31]; end
			default: begin ma = '0; end
		endcase
	end

	assign req_take = (state_q == S_IDLE) && req_valid && !out_ch.valid;
	assign out_ch.plant_out = out_q;
	assign out_ch.saturated = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			y_q <= '0;
			out_ch.valid <= 1'b0;
			out_q <= '0;
			sat_q <= 1'b0;
			u_q <= '0; sneg_q <= 1'b0; acc_q <= '0; dcap_q <= 1'b0; q_q <= '0;
			x_q <= '0; x2_q <= '0; t_q <= '0; s_q <= '0; dmag_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_take) begin
					u_q <= req.u;
					acc_q <= '0;
					dmag_q <= '0;
					dcap_q <= 1'b0;
					if (req.restart) begin
						y_q <= cfg.init;
						out_q <= cfg.init;
						sat_q <= 1'b0;
						out_ch.valid <= 1'b1;
					end else begin
						state_q <= cfg.mode ? S_PH : S_A1Y;
					end
				end
				S_PH: begin
					x_q <= xm;
					sneg_q <= phase[31];
					state_q <= S_X2;
				end
				S_X2: begin x2_q <= umul[61:30]; state_q <= S_T; end
				S_T:  begin t_q <= PolyB - umul[61:30]; state_q <= S_T2; end
				S_T2: begin t_q <= PolyA - umul[61:30]; state_q <= S_M; end
				S_M: begin
					s_q <= sneg_q ? -32'(umul[61:30] >> (30 - FRAC_BITS))
					              : 32'(umul[61:30] >> (30 - FRAC_BITS));
					state_q <= S_B2S;
				end
				S_B2S: begin acc_q <= fl; state_q <= S_A1Y; end
				S_A1Y: begin acc_q <= acc_q + fl; state_q <= S_B1U; end
				S_B1U: begin
					acc_q <= acc_q + fl;
					state_q <= cfg.mode ? S_YY : S_SUM;
				end
				S_YY: begin q_q <= fl; state_q <= S_DLO; end
				S_DLO: begin dmag_q <= umul >> FRAC_BITS; state_q <= S_DHI; end
				S_DHI: begin
					if (q_q[62:31] != '0) begin
						if (umul >= (64'd1 << (29 + FRAC_BITS))) dcap_q <= 1'b1;
						else dmag_q <= dsum;
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (dcap_q || dmag_q > (64'd1 << 60)) dmag_q <= 64'd1 << 60;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if ($signed(fin) > 65'sd2147483647) begin
						y_q <= 32'h7fff_ffff; sat_q <= 1'b1;
					end else if ($signed(fin) < -65'sd2147483648) begin
						y_q <= 32'h8000_0000; sat_q <= 1'b1;
					end else begin
						y_q <= fin[31:0]; sat_q <= 1'b0;
					end
					out_q <= ($signed(fin) > 65'sd2147483647) ? 32'h7fff_ffff :
					         ($signed(fin) < -65'sd2147483648) ? 32'h8000_0000 : fin[31:0];
					out_ch.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ntps_cfg.sv =====
`default_nettype none
// apb register file
module ntps_cfg
	import ntps_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	cfg_t cfg_q;
	assign cfg = cfg_q;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			REG_A1:   prdata = cfg_q.a1;
			REG_A2:   prdata = cfg_q.a2;
			REG_B1:   prdata = cfg_q.b1;
			REG_B2:   prdata = cfg_q.b2;
			REG_MODE: prdata = {31'd0, cfg_q.mode};
			REG_INIT: prdata = cfg_q.init;
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				REG_A1:   cfg_q.a1 <= pwdata;
				REG_A2:   cfg_q.a2 <= pwdata;
				REG_B1:   cfg_q.b1 <= pwdata;
				REG_B2:   cfg_q.b2 <= pwdata;
				REG_MODE: cfg_q.mode <= pwdata[0];
				REG_INIT: cfg_q.init <= pwdata;
				default:  cfg_q <= cfg_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/nonlinear_thermal_plant_step_unit.sv =====
`default_nettype none
// channel   | dir | payload                      | handshake
// in_ch     | in  | control_in[31:0], restart    | valid/ready
// out_ch    | out | plant_out[31:0], saturated   | valid/ready
// apb       | in  | 32-bit registers at 4*i      | psel/penable, pready high
//
// a restart request loads init into the state and the output, with no multiply steps
// nonlinear requests add sine and damping multiplies to a1*y + b1*u, stepped by the sequencer
// a two-entry front queue keeps taking requests while the datapath works, until it is full
// reset clears state, registers and the queue; out_ch stalls hold the sequencer in idle
`include "nonlinear_thermal_plant_step_unit_defines.svh"
module nonlinear_thermal_plant_step_unit
	import ntps_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	ntps_in_if.sink               in_ch,
	ntps_out_if.source            out_ch,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	cfg_t cfg;
	req_t req;
	logic req_valid, req_take;

	// register file
	ntps_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// front: request queue
	ntps_front u_front (
		.clk, .arst_n, .in_ch, .req, .req_valid, .req_take
	);

	// back: multiply sequencer and saturation
	ntps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .cfg, .req, .req_valid, .req_take, .out_ch
	);

	`NTP_ASSERT_IMPL(a_take_valid, clk, arst_n, req_take, req_valid)
	`NTP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`NTP_ASSERT_IMPL(a_no_take_busy, clk, arst_n, out_ch.valid, !req_take)
endmodule
`default_nettype wire

// ===== verif/nonlinear_thermal_plant_step_unit_tb.sv =====
`timescale 1ns / 1ps
module nonlinear_thermal_plant_step_unit_tb;
	import ntps_pkg::*;

	localparam int FracBits = FracBitsDefault;
	localparam int SettleCycles = 40;       // longest request is the nonlinear one, with margin
	localparam logic [31:0] QOne = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ntps_in_if in_ch ();
	ntps_out_if out_ch ();

	nonlinear_thermal_plant_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	typedef struct {
		logic [31:0] plant_out;
		logic        saturated;
	} plant_result_t;

	// shadow of the register file and the plant state
	logic signed [31:0] sh_a1, sh_a2, sh_b1, sh_b2, sh_init;
	logic sh_mode;
	longint plant_y;

	plant_result_t expected_results[$];
	int errors;
	bit sender_no_gap;      // stretches with no idling on the request side
	bit receiver_no_stall;  // stretches with no idling on the result side
	int receiver_hold;      // long hold-off request for the result side

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sine of u in Q(FracBits), table-free polynomial after quadrant reduction
	function automatic longint plant_sine(logic signed [31:0] u);
		logic [63:0] turns;
		logic [31:0] phase;
		logic [1:0] quad;
		longint unsigned x, x2, t, t2, m;
		longint s;
		turns = longint'(u) * longint'(TurnPerRad);
		phase = turns[FracBits +: 32];
		quad = phase[31:30];
		x = longint'(phase[29:0]);
		if (quad[0]) begin
			x = (64'd1 << 30) - x;
		end
		x2 = (x * x) >> 30;
		t = longint'(PolyB) - ((x2 * longint'(PolyC)) >> 30);
		t2 = longint'(PolyA) - ((x2 * t) >> 30);
		m = (x * t2) >> 30;
		s = longint'(m >> (30 - FracBits));
		return quad[1] ? -s : s;
	endfunction

	// a2 * y * y with the magnitude capped at 2^60
	function automatic longint plant_damping(longint a2, longint y);
		longint unsigned sq, am, hi, lo, mag, t;
		sq = longint'((y * y) >>> FracBits);
		am = (a2 < 0) ? -a2 : a2;
		hi = sq >> 31;
		lo = sq & 64'h7FFF_FFFF;
		mag = (am * lo) >> FracBits;
		if (hi != 0) begin
			t = am * hi;
			if (t >= (64'd1 << (29 + FracBits))) begin
				mag = 64'd1 << 60;
			end else begin
				mag = mag + (t << (31 - FracBits));
			end
		end
		if (mag > (64'd1 << 60)) begin
			mag = 64'd1 << 60;
		end
		return (a2 < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// one plant step: advances the shadow state and returns the expected result
	function automatic plant_result_t plant_step(logic signed [31:0] u, logic restart);
		plant_result_t r;
		longint sum;
		r.saturated = 1'b0;
		if (restart) begin
			plant_y = longint'(sh_init);
		end else begin
			sum = ((longint'(sh_a1) * plant_y) >>> FracBits)
				+ ((longint'(sh_b1) * longint'(u)) >>> FracBits);
			if (sh_mode) begin
				sum = sum - plant_damping(longint'(sh_a2), plant_y)
					+ ((longint'(sh_b2) * plant_sine(u)) >>> FracBits);
			end
			if (sum > 64'sd2147483647) begin
				sum = 64'sd2147483647;
				r.saturated = 1'b1;
			end else if (sum < -64'sd2147483648) begin
				sum = -64'sd2147483648;
				r.saturated = 1'b1;
			end
			plant_y = sum;
		end
		r.plant_out = plant_y[31:0];
		return r;
	endfunction

	// request monitor: sampled mid-cycle, acceptance happens at the next rising edge
	always @(negedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_results.push_back(plant_step(in_ch.control_in, in_ch.restart));
		end
	end

	// result checker
	always @(negedge clk) begin
		plant_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result plant_out=%h saturated=%b", $time,
					out_ch.plant_out, out_ch.saturated);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_ch.plant_out !== want.plant_out) begin
					$display("%0t: plant_out expected %h actual %h", $time,
						want.plant_out, out_ch.plant_out);
					errors++;
				end
				if (out_ch.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, out_ch.saturated);
					errors++;
				end
			end
		end
	end

	// result side: random stall per result, plus a long hold-off on request
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (receiver_hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (receiver_hold) @(posedge clk);
				receiver_hold = 0;
			end
			n = receiver_no_stall ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(negedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// register write over the apb port, setup phase then access phase
	task automatic cfg_write(reg_addr_t addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (addr)
			REG_A1: sh_a1 = data;
			REG_A2: sh_a2 = data;
			REG_B1: sh_b1 = data;
			REG_B2: sh_b2 = data;
			REG_MODE: sh_mode = data[0];
			REG_INIT: sh_init = data;
			default: ;
		endcase
	endtask

	task automatic cfg_all(logic [31:0] a1, logic [31:0] a2, logic [31:0] b1,
		logic [31:0] b2, logic [31:0] mode, logic [31:0] init);
		cfg_write(REG_A1, a1);
		cfg_write(REG_A2, a2);
		cfg_write(REG_B1, b1);
		cfg_write(REG_B2, b2);
		cfg_write(REG_MODE, mode);
		cfg_write(REG_INIT, init);
	endtask

	// offers one request after a random gap; valid stays high on return
	task automatic send_sample(logic [31:0] u, logic restart);
		int gap;
		gap = sender_no_gap ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.control_in <= u;
		in_ch.restart <= restart;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
	endtask

	// lowers valid and waits until every result is back, then lets the datapath settle
	task automatic drain();
		int guard;
		in_ch.valid <= 1'b0;
		guard = 0;
		while (expected_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom();
			4: return 32'(int'(QOne) - $urandom_range(0, 40000));   // stable feedback
			5: return 32'($urandom_range(0, 262143) - 131072);
			default: return 32'(int'(QOne) / 8 - $urandom_range(0, 16384));
		endcase
	endfunction

	function automatic logic [31:0] rand_control();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return 32'($urandom_range(0, 1048575) - 524288);   // about +-8 rad
		endcase
	endfunction

	task automatic test_reset_values();
		// all registers zero: every step yields zero
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h1234_5678, 1'b1);
		drain();
	endtask

	task automatic test_linear_directed();
		cfg_all(QOne, 32'h0, QOne, 32'h0, 32'h0, 32'h0003_0000);
		send_sample(32'h0, 1'b1);
		send_sample(QOne, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);   // saturates high
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b1);   // restart ignores u
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);   // saturates low
		send_sample(32'hFFFF_FFFF, 1'b0);
		drain();
	endtask

	task automatic test_nonlinear_directed();
		// only the low mode bit counts
		cfg_all(32'h0000_8000, 32'h0000_0100, 32'h0000_4000, QOne, 32'hFFFF_FFFE, 32'h0);
		send_sample(32'h0001_921F, 1'b0);   // still linear, mode bit 0
		drain();
		cfg_write(REG_MODE, 32'h0000_0003);
		send_sample(32'h0, 1'b1);
		send_sample(32'h0001_921F, 1'b0);   // pi/2
		send_sample(32'h0003_243F, 1'b0);   // pi
		send_sample(32'h0004_B65F, 1'b0);   // 3pi/2
		send_sample(32'hFFFE_6DE1, 1'b0);   // -pi/2
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		drain();
		// large state with extreme damping and gains drives both clamps
		cfg_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
			32'h7FFF_FFFF);
		send_sample(32'h0, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		drain();
		cfg_write(REG_INIT, 32'h8000_0000);
		cfg_write(REG_A2, 32'h7FFF_FFFF);
		send_sample(32'h0, 1'b1);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h0, 1'b0);
		drain();
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			cfg_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), $urandom(),
				$urandom());
			sender_no_gap = (p % 4 == 1);
			receiver_no_stall = (p % 4 == 2);
			for (int i = 0; i < per_phase; i++) begin
				send_sample(rand_control(), ($urandom_range(0, 9) == 0));
			end
			drain();
		end
		sender_no_gap = 1'b0;
		receiver_no_stall = 1'b0;
	endtask

	task automatic test_backpressure();
		cfg_all(32'h0000_F000, 32'h0000_0400, QOne, 32'h0002_0000, 32'h1, 32'h0001_0000);
		// results held off while requests keep coming: the front queue fills
		receiver_hold = 300;
		sender_no_gap = 1'b1;
		send_sample(32'h0, 1'b1);
		for (int i = 0; i < 12; i++) begin
			send_sample(rand_control(), 1'b0);
		end
		sender_no_gap = 1'b0;
		// sender pauses until every result has come
		drain();
		for (int i = 0; i < 12; i++) begin
			send_sample(rand_control(), 1'b0);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		sender_no_gap = 1'b0;
		receiver_no_stall = 1'b0;
		receiver_hold = 0;
		sh_a1 = '0;
		sh_a2 = '0;
		sh_b1 = '0;
		sh_b2 = '0;
		sh_mode = 1'b0;
		sh_init = '0;
		plant_y = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.control_in = '0;
		in_ch.restart = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_values();
		test_linear_directed();
		test_nonlinear_directed();
		test_backpressure();
		test_random_phases(12, 150);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ntps_pkg.sv
rtl/ntps_if.sv
rtl/ntps_front.sv
rtl/ntps_back.sv
rtl/ntps_cfg.sv
rtl/nonlinear_thermal_plant_step_unit.sv
verif/nonlinear_thermal_plant_step_unit_tb.sv
